// ===== sv/scurve_profile_evaluator_assert.svh =====
// assertion macros for the s-curve evaluator
// used by scurve_profile_evaluator.sv, needs nothing else
`ifndef SCURVE_PROFILE_EVALUATOR_ASSERT_SVH
`define SCURVE_PROFILE_EVALUATOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spe_pkg.sv =====
// types and constants of the s-curve profile evaluator
// no dependencies
package spe_pkg;

  // sequencer states, at most one multiply per state
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_JT,
    ST_TT,
    ST_X,
    ST_Y,
    ST_Z,
    ST_SEL,
    ST_T2,
    ST_T3,
    ST_JT3,
    ST_DIV,
    ST_HA,
    ST_WT,
    ST_JTL,
    ST_HJ,
    ST_AT,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEG_ONE,
    SEG_TWO,
    SEG_THREE,
    SEG_PAST
  } seg_t;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SEG0_ACCEL  = 3'd0;
  localparam cfg_idx_t CFG_SEG0_JERK   = 3'd1;
  localparam cfg_idx_t CFG_START_SPEED = 3'd2;
  localparam cfg_idx_t CFG_SEG0_TIME   = 3'd3;
  localparam cfg_idx_t CFG_SEG1_TIME   = 3'd4;
  localparam cfg_idx_t CFG_SEG2_JERK   = 3'd5;
  localparam cfg_idx_t CFG_SEG2_TIME   = 3'd6;

  // n / 6 == (n * ceil(2^34 / 6)) >> 34 for every 32-bit unsigned n
  localparam logic signed [32:0] DIV6_RECIP = 33'sh0AAAAAAAB;
  localparam int                 DIV6_SHIFT = 34;

endpackage

// ===== sv/scurve_profile_evaluator.sv =====
// s-curve (jerk-limited, three segment) profile evaluator, top level
// depends on spe_pkg and scurve_profile_evaluator_assert.svh
//
// channel | direction | handshake         | payload
// in_     | input     | in_valid/in_stall | in_time_point
// out_    | output    | out_valid/out_stall | accel, speed, distance, running
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// after a request is accepted the sequencer steps through its work states, then the result
// is offered; the next request is taken the cycle after the result leaves
// all products go through one shared 33x33 signed multiplier, one per cycle
// synchronous active-low reset clears the sequencer, configuration and the
// remembered distances and outputs; a stalled result holds, and no request
// nor configuration write is taken until it has left
`include "scurve_profile_evaluator_assert.svh"

module scurve_profile_evaluator
  import spe_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_time_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_accel_out,
  output logic signed [31:0] out_speed_out,
  output logic signed [31:0] out_distance_out,
  output logic               out_profile_running,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_idx_t           cfg_index,
  input  logic        [31:0] cfg_data
);

  state_t state_r, state_nxt;

  // configuration
  logic signed [31:0] seg0_accel_r, seg0_jerk_r, start_speed_r, seg2_jerk_r;
  logic        [30:0] seg0_time_r, seg1_time_r, seg2_time_r;

  // remembered state
  logic signed [31:0] first_dist_r, second_dist_r;
  logic signed [31:0] held_accel_r, held_speed_r, held_dist_r;
  logic               run_r;
  seg_t               seg_r;

  // working registers
  logic signed [31:0] tp_r;
  logic        [31:0] b1_r;
  logic        [32:0] b2_r;
  logic signed [31:0] jt_r, tt_r, x_r, y_r, z_r, a1_r, w1_r;
  logic signed [31:0] a_r, j_r, w_r, t_r, t2_r, t3_r, p_r;
  logic        [31:0] q_r;
  logic signed [31:0] dc_r, ha_r, wt_r, jtl_r, hj_r, at_r, dpart_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] mul_fx;
  logic        [31:0] p_mag;

  logic in_acc, out_acc, cfg_acc;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [31:0] half32(input logic signed [31:0] v);
    return {v[31], v[31:1]};
  endfunction

  assign prod    = mul_a * mul_b;
  assign mul_fx  = prod[FRAC_BITS +: 32];
  assign p_mag   = p_r[31] ? 32'(-p_r) : p_r;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_acc = cfg_valid && cfg_ready;

  // segment decision, exact wide compares
  logic signed [33:0] tp_x, b0_x, b1_x, b2_x;
  assign tp_x = {{2{tp_r[31]}}, tp_r};
  assign b0_x = {3'b000, seg0_time_r};
  assign b1_x = {2'b00, b1_r};
  assign b2_x = {1'b0, b2_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_JT;
      ST_JT:   state_nxt = ST_TT;
      ST_TT:   state_nxt = ST_X;
      ST_X:    state_nxt = ST_Y;
      ST_Y:    state_nxt = ST_Z;
      ST_Z:    state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_T2;
      ST_T2:   state_nxt = ST_T3;
      ST_T3:   state_nxt = ST_JT3;
      ST_JT3:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_HA;
      ST_HA:   state_nxt = ST_WT;
      ST_WT:   state_nxt = ST_JTL;
      ST_JTL:  state_nxt = ST_HJ;
      ST_HJ:   state_nxt = ST_AT;
      ST_AT:   state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (out_acc) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshakes and multiplier operands
  always_comb begin
    // nothing is taken while in reset
    in_stall  = !rst_n || (state_r != ST_IDLE);
    cfg_ready = rst_n && (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_JT:  begin mul_a = sx33(seg0_jerk_r);         mul_b = {2'b00, seg0_time_r}; end
      ST_TT:  begin mul_a = {2'b00, seg0_time_r};      mul_b = {2'b00, seg0_time_r}; end
      ST_X:   begin mul_a = sx33(half32(seg0_jerk_r)); mul_b = sx33(tt_r); end
      ST_Y:   begin mul_a = sx33(seg0_accel_r);        mul_b = {2'b00, seg0_time_r}; end
      ST_Z:   begin mul_a = sx33(a1_r);                mul_b = {2'b00, seg1_time_r}; end
      ST_T2:  begin mul_a = sx33(t_r);                 mul_b = sx33(t_r); end
      ST_T3:  begin mul_a = sx33(t2_r);                mul_b = sx33(t_r); end
      ST_JT3: begin mul_a = sx33(j_r);                 mul_b = sx33(t3_r); end
      ST_DIV: begin mul_a = {1'b0, p_mag};             mul_b = DIV6_RECIP; end
      ST_HA:  begin mul_a = sx33(half32(a_r));         mul_b = sx33(t2_r); end
      ST_WT:  begin mul_a = sx33(w_r);                 mul_b = sx33(t_r); end
      ST_JTL: begin mul_a = sx33(j_r);                 mul_b = sx33(t_r); end
      ST_HJ:  begin mul_a = sx33(half32(j_r));         mul_b = sx33(t2_r); end
      ST_AT:  begin mul_a = sx33(a_r);                 mul_b = sx33(t_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // control, configuration and remembered state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      seg0_accel_r  <= '0;
      seg0_jerk_r   <= '0;
      start_speed_r <= '0;
      seg0_time_r   <= '0;
      seg1_time_r   <= '0;
      seg2_jerk_r   <= '0;
      seg2_time_r   <= '0;
      first_dist_r  <= '0;
      second_dist_r <= '0;
      held_accel_r  <= '0;
      held_speed_r  <= '0;
      held_dist_r   <= '0;
      run_r         <= 1'b0;
      seg_r         <= SEG_ONE;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        case (cfg_index)
          CFG_SEG0_ACCEL:  seg0_accel_r  <= cfg_data;
          CFG_SEG0_JERK:   seg0_jerk_r   <= cfg_data;
          CFG_START_SPEED: start_speed_r <= cfg_data;
          CFG_SEG0_TIME:   seg0_time_r   <= cfg_data[30:0];
          CFG_SEG1_TIME:   seg1_time_r   <= cfg_data[30:0];
          CFG_SEG2_JERK:   seg2_jerk_r   <= cfg_data;
          CFG_SEG2_TIME:   seg2_time_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (state_r == ST_SEL) begin
        if (tp_x <= b0_x)      seg_r <= SEG_ONE;
        else if (tp_x <= b1_x) seg_r <= SEG_TWO;
        else if (tp_x <= b2_x) seg_r <= SEG_THREE;
        else                   seg_r <= SEG_PAST;
        run_r <= (tp_x <= b2_x);
      end
      if (state_r == ST_FIN && run_r) begin
        held_accel_r <= a_r + jtl_r;
        held_speed_r <= hj_r + at_r + w_r;
        case (seg_r)
          SEG_ONE: begin
            first_dist_r  <= dpart_r;
            second_dist_r <= '0;
            held_dist_r   <= dpart_r;
          end
          SEG_TWO: begin
            second_dist_r <= dpart_r;
            held_dist_r   <= first_dist_r + dpart_r;
          end
          default: held_dist_r <= first_dist_r + second_dist_r + dpart_r;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_acc) tp_r <= in_time_point;
      ST_JT: begin
        jt_r <= mul_fx;
        b1_r <= {1'b0, seg0_time_r} + {1'b0, seg1_time_r};
      end
      ST_TT: begin
        tt_r <= mul_fx;
        b2_r <= {1'b0, b1_r} + {2'b00, seg2_time_r};
        a1_r <= seg0_accel_r + jt_r;
      end
      ST_X: x_r <= mul_fx;
      ST_Y: y_r <= mul_fx;
      ST_Z: begin
        z_r  <= mul_fx;
        w1_r <= x_r + y_r + start_speed_r;
      end
      ST_SEL: begin
        if (tp_x <= b0_x) begin
          a_r <= seg0_accel_r; j_r <= seg0_jerk_r; w_r <= start_speed_r; t_r <= tp_r;
        end else if (tp_x <= b1_x) begin
          a_r <= a1_r; j_r <= '0; w_r <= w1_r;
          t_r <= tp_r - $signed({1'b0, seg0_time_r});
        end else if (tp_x <= b2_x) begin
          a_r <= a1_r; j_r <= seg2_jerk_r; w_r <= z_r + w1_r;
          t_r <= tp_r - $signed(b1_r);
        end else begin
          a_r <= '0; j_r <= '0; w_r <= '0; t_r <= '0;
        end
      end
      ST_T2:  t2_r <= mul_fx;
      ST_T3:  t3_r <= mul_fx;
      ST_JT3: p_r  <= mul_fx;
      ST_DIV: q_r  <= prod[DIV6_SHIFT +: 32];
      ST_HA: begin
        ha_r <= mul_fx;
        // truncation toward zero: divide the magnitude, restore the sign
        dc_r <= p_r[31] ? $signed(32'(-q_r)) : $signed(q_r);
      end
      ST_WT: begin
        wt_r    <= mul_fx;
        dpart_r <= dc_r + ha_r;
      end
      ST_JTL: begin
        jtl_r   <= mul_fx;
        dpart_r <= dpart_r + wt_r;
      end
      ST_HJ: hj_r <= mul_fx;
      ST_AT: at_r <= mul_fx;
      default: ;
    endcase
  end

  assign out_accel_out       = held_accel_r;
  assign out_speed_out       = held_speed_r;
  assign out_distance_out    = held_dist_r;
  assign out_profile_running = run_r;

  `SPE_ASSERT_NEXT(a_start, clk, rst_n, in_acc, state_r == ST_JT, "request did not start sequencer")
  `SPE_ASSERT_NOW(a_busy, clk, rst_n, out_valid, in_stall && !cfg_ready, "taking work while result pending")
  `SPE_ASSERT_NEXT(a_past_hold, clk, rst_n, state_r == ST_FIN && !run_r, $stable(held_accel_r) && $stable(held_speed_r) && $stable(held_dist_r), "held outputs changed past profile end")
  `SPE_ASSERT_NEXT(a_seg_one, clk, rst_n, state_r == ST_FIN && run_r && seg_r == SEG_ONE, second_dist_r == 32'sd0 && held_dist_r == first_dist_r, "first segment distance bookkeeping wrong")

endmodule
